>>> rtl/cnalu_pkg.sv
package cnalu_pkg;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_CONJ = 3'd4,
    CMD_MAG  = 3'd5,
    CMD_ARG  = 3'd6
  } cmd_e;

  localparam int unsigned ITER_STEPS   = 32;
  localparam int unsigned CORDIC_STEPS = 31;

  localparam logic [31:0] PI_HALF_Q30 = 32'h6487_ED51;

  localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001,
    32'h00000000
  };

endpackage

>>> rtl/complex_number_alu_core.sv
// Complex arithmetic unit, signed Q16.16 operands and results.
// Command channel: a command with two complex operands is taken at a rising
// edge where start_i is high and busy_o is low. busy_o is always low, so a
// new command may be issued in every cycle.
// Result channel: res_valid_o is high for exactly one cycle per command, in
// command order, with res_real_o, res_imag_o, divide_by_zero_o and
// overflow_o. The receiver cannot stall; it must take each result beat.
// Every command runs through the same pipeline, whatever its kind.
// Throughput: one command per cycle.
// The pipeline holds three stages of multiply, sum and normalization, then
// the 32-stage divider and square-root arrays and the 31-stage CORDIC array,
// which run side by side, and then an output register.
// Reset: rst_ni clears all valid bits; commands in flight are dropped and no
// result beat is produced until a new command is accepted.
module complex_number_alu_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] a_real_i,
  input  logic [31:0] a_imag_i,
  input  logic [31:0] b_real_i,
  input  logic [31:0] b_imag_i,
  output logic        res_valid_o,
  output logic [31:0] res_real_o,
  output logic [31:0] res_imag_o,
  output logic        divide_by_zero_o,
  output logic        overflow_o
);

  localparam int unsigned NSTEP = cnalu_pkg::ITER_STEPS;

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] m;
  } cvec_t;

  typedef struct packed {
    cnalu_pkg::cmd_e cmd;
    logic [31:0]     e_re;
    logic [31:0]     e_im;
    logic            e_ov;
    logic [63:0]     m0;
    logic [63:0]     m1;
    logic [63:0]     m2;
    logic [63:0]     m3;
    logic [63:0]     m4;
    logic [63:0]     m5;
    cvec_t           cv;
    logic            czero;
  } p1_t;

  typedef struct packed {
    cnalu_pkg::cmd_e cmd;
    logic [31:0]     e_re;
    logic [31:0]     e_im;
    logic            e_ov;
    logic [64:0]     mre;
    logic [64:0]     mim;
    logic [64:0]     nre;
    logic [64:0]     nim;
    logic [63:0]     den;
    cvec_t           cv;
    logic            czero;
  } p2_t;

  typedef struct packed {
    cnalu_pkg::cmd_e cmd;
    logic [31:0]     e_re;
    logic [31:0]     e_im;
    logic            e_ov;
    logic            dz;
    logic            neg_r;
    logic            neg_i;
    logic            big_r;
    logic            big_i;
    logic [63:0]     den;
    logic [63:0]     rem_r;
    logic [63:0]     rem_i;
    logic [31:0]     low_r;
    logic [31:0]     low_i;
    logic [31:0]     q_r;
    logic [31:0]     q_i;
    logic [63:0]     snum;
    logic [34:0]     srem;
    logic [31:0]     sroot;
    logic [63:0]     cx;
    logic [63:0]     cy;
    logic [33:0]     cz;
    logic            czero;
  } it_t;

  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      sat32 = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -66'sd2147483648) begin
      sat32 = {1'b1, 32'h8000_0000};
    end else begin
      sat32 = {1'b0, v[31:0]};
    end
  endfunction

  function automatic cvec_t cnorm(input cvec_t v, input int k);
    cvec_t r;
    r = v;
    if (v.m < (64'd1 << (60 - k))) begin
      r.x = v.x << k;
      r.y = v.y << k;
      r.m = v.m << k;
    end
    return r;
  endfunction

  function automatic logic [32:0] div_fin(input logic neg, input logic big,
                                          input logic [31:0] q);
    if (big) begin
      div_fin = neg ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
    end else if (!neg) begin
      div_fin = q[31] ? {1'b1, 32'h7FFF_FFFF} : {1'b0, q};
    end else if (q > 32'h8000_0000) begin
      div_fin = {1'b1, 32'h8000_0000};
    end else begin
      div_fin = {1'b0, 32'(-q)};
    end
  endfunction

  logic signed [31:0] ar, ai, br, bi, sq_a, sq_b;
  logic signed [63:0] pr0, pr1, pr2, pr3, pr4, pr5;
  logic               accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign ar   = a_real_i;
  assign ai   = a_imag_i;
  assign br   = b_real_i;
  assign bi   = b_imag_i;
  assign sq_a = (cnalu_pkg::cmd_e'(command_i) == cnalu_pkg::CMD_MAG) ? ar : br;
  assign sq_b = (cnalu_pkg::cmd_e'(command_i) == cnalu_pkg::CMD_MAG) ? ai : bi;
  assign pr0  = ar * br;
  assign pr1  = ai * bi;
  assign pr2  = ar * bi;
  assign pr3  = ai * br;
  assign pr4  = sq_a * sq_a;
  assign pr5  = sq_b * sq_b;

  p1_t p1_d, p1_q;
  p2_t p2_d, p2_q;
  it_t it0_d;
  it_t st_q [NSTEP+1];
  it_t st_d [NSTEP];
  logic p1_v_q, p2_v_q;
  logic [NSTEP:0] it_v_q;

  logic        out_v_q;
  logic [31:0] res_real_d, res_real_q, res_imag_d, res_imag_q;
  logic        dz_d, dz_q, ov_d, ov_q;

  always_comb begin
    logic [32:0] s_re, s_im;
    logic [31:0] abs_r, abs_i;
    cvec_t       v;
    p1_d       = '0;
    p1_d.cmd   = cnalu_pkg::cmd_e'(command_i);
    p1_d.m0    = pr0;
    p1_d.m1    = pr1;
    p1_d.m2    = pr2;
    p1_d.m3    = pr3;
    p1_d.m4    = pr4;
    p1_d.m5    = pr5;
    s_re       = '0;
    s_im       = '0;
    unique case (p1_d.cmd)
      cnalu_pkg::CMD_ADD: begin
        s_re = sat32(66'(ar) + 66'(br));
        s_im = sat32(66'(ai) + 66'(bi));
      end
      cnalu_pkg::CMD_SUB: begin
        s_re = sat32(66'(ar) - 66'(br));
        s_im = sat32(66'(ai) - 66'(bi));
      end
      cnalu_pkg::CMD_CONJ: begin
        s_re = {1'b0, a_real_i};
        s_im = sat32(-66'(ai));
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    p1_d.e_re  = s_re[31:0];
    p1_d.e_im  = s_im[31:0];
    p1_d.e_ov  = s_re[32] | s_im[32];
    abs_r      = ar[31] ? 32'(-ar) : a_real_i;
    abs_i      = ai[31] ? 32'(-ai) : a_imag_i;
    v.x        = 64'(ar) << 28;
    v.y        = 64'(ai) << 28;
    v.m        = {32'd0, (abs_r > abs_i) ? abs_r : abs_i} << 28;
    v          = cnorm(v, 16);
    v          = cnorm(v, 8);
    p1_d.cv    = v;
    p1_d.czero = (a_real_i == '0) && (a_imag_i == '0);
  end

  always_comb begin
    cvec_t v;
    p2_d       = '0;
    p2_d.cmd   = p1_q.cmd;
    p2_d.e_re  = p1_q.e_re;
    p2_d.e_im  = p1_q.e_im;
    p2_d.e_ov  = p1_q.e_ov;
    p2_d.mre   = 65'($signed(p1_q.m0)) - 65'($signed(p1_q.m1));
    p2_d.mim   = 65'($signed(p1_q.m2)) + 65'($signed(p1_q.m3));
    p2_d.nre   = 65'($signed(p1_q.m0)) + 65'($signed(p1_q.m1));
    p2_d.nim   = 65'($signed(p1_q.m3)) - 65'($signed(p1_q.m2));
    p2_d.den   = p1_q.m4 + p1_q.m5;
    v          = cnorm(p1_q.cv, 4);
    v          = cnorm(v, 2);
    v          = cnorm(v, 1);
    v.x        = v.x << 1;
    v.y        = v.y << 1;
    v.m        = v.m << 1;
    p2_d.cv    = v;
    p2_d.czero = p1_q.czero;
  end

  always_comb begin
    logic signed [65:0] t_re, t_im;
    logic [32:0]        s_re, s_im;
    logic [63:0]        abs_r, abs_i;
    it0_d       = '0;
    it0_d.cmd   = p2_q.cmd;
    t_re        = (66'($signed(p2_q.mre)) + 66'sd32768) >>> 16;
    t_im        = (66'($signed(p2_q.mim)) + 66'sd32768) >>> 16;
    s_re        = sat32(t_re);
    s_im        = sat32(t_im);
    if (p2_q.cmd == cnalu_pkg::CMD_MUL) begin
      it0_d.e_re = s_re[31:0];
      it0_d.e_im = s_im[31:0];
      it0_d.e_ov = s_re[32] | s_im[32];
    end else begin
      it0_d.e_re = p2_q.e_re;
      it0_d.e_im = p2_q.e_im;
      it0_d.e_ov = p2_q.e_ov;
    end
    it0_d.neg_r = p2_q.nre[64];
    it0_d.neg_i = p2_q.nim[64];
    abs_r       = p2_q.nre[64] ? 64'(-p2_q.nre) : p2_q.nre[63:0];
    abs_i       = p2_q.nim[64] ? 64'(-p2_q.nim) : p2_q.nim[63:0];
    it0_d.den   = p2_q.den;
    it0_d.dz    = (p2_q.den == '0);
    it0_d.big_r = {16'd0, abs_r} >= {p2_q.den, 16'd0};
    it0_d.big_i = {16'd0, abs_i} >= {p2_q.den, 16'd0};
    it0_d.rem_r = {16'd0, abs_r[63:16]};
    it0_d.rem_i = {16'd0, abs_i[63:16]};
    it0_d.low_r = {abs_r[15:0], 16'd0};
    it0_d.low_i = {abs_i[15:0], 16'd0};
    it0_d.snum  = p2_q.den;
    it0_d.czero = p2_q.czero;
    it0_d.cx    = p2_q.cv.x;
    it0_d.cy    = p2_q.cv.y;
    if ($signed(p2_q.cv.x) < 0) begin
      if ($signed(p2_q.cv.y) >= 0) begin
        it0_d.cx = p2_q.cv.y;
        it0_d.cy = 64'(-p2_q.cv.x);
        it0_d.cz = {2'b00, cnalu_pkg::PI_HALF_Q30};
      end else begin
        it0_d.cx = 64'(-p2_q.cv.y);
        it0_d.cy = p2_q.cv.x;
        it0_d.cz = 34'(-{2'b00, cnalu_pkg::PI_HALF_Q30});
      end
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int unsigned AIDX = (j < cnalu_pkg::CORDIC_STEPS) ? j : 0;
    always_comb begin
      logic [63:0] r2_r, r2_i, dx, dy;
      logic [34:0] rem2, trial;
      st_d[j] = st_q[j];
      r2_r = {st_q[j].rem_r[62:0], st_q[j].low_r[31]};
      r2_i = {st_q[j].rem_i[62:0], st_q[j].low_i[31]};
      st_d[j].low_r = st_q[j].low_r << 1;
      st_d[j].low_i = st_q[j].low_i << 1;
      if (r2_r >= st_q[j].den) begin
        st_d[j].rem_r = r2_r - st_q[j].den;
        st_d[j].q_r   = {st_q[j].q_r[30:0], 1'b1};
      end else begin
        st_d[j].rem_r = r2_r;
        st_d[j].q_r   = {st_q[j].q_r[30:0], 1'b0};
      end
      if (r2_i >= st_q[j].den) begin
        st_d[j].rem_i = r2_i - st_q[j].den;
        st_d[j].q_i   = {st_q[j].q_i[30:0], 1'b1};
      end else begin
        st_d[j].rem_i = r2_i;
        st_d[j].q_i   = {st_q[j].q_i[30:0], 1'b0};
      end
      rem2  = {st_q[j].srem[32:0], st_q[j].snum[63:62]};
      trial = {1'b0, st_q[j].sroot, 2'b01};
      st_d[j].snum = st_q[j].snum << 2;
      if (rem2 >= trial) begin
        st_d[j].srem  = rem2 - trial;
        st_d[j].sroot = {st_q[j].sroot[30:0], 1'b1};
      end else begin
        st_d[j].srem  = rem2;
        st_d[j].sroot = {st_q[j].sroot[30:0], 1'b0};
      end
      dx = $signed(st_q[j].cy) >>> j;
      dy = $signed(st_q[j].cx) >>> j;
      if (j < cnalu_pkg::CORDIC_STEPS) begin
        if ($signed(st_q[j].cy) > 0) begin
          st_d[j].cx = st_q[j].cx + dx;
          st_d[j].cy = st_q[j].cy - dy;
          st_d[j].cz = st_q[j].cz + {2'b00, cnalu_pkg::ATAN_Q30[AIDX]};
        end else begin
          st_d[j].cx = st_q[j].cx - dx;
          st_d[j].cy = st_q[j].cy + dy;
          st_d[j].cz = st_q[j].cz - {2'b00, cnalu_pkg::ATAN_Q30[AIDX]};
        end
      end
    end
  end

  always_comb begin
    logic [32:0]        f_re, f_im;
    logic signed [33:0] zr;
    res_real_d = st_q[NSTEP].e_re;
    res_imag_d = st_q[NSTEP].e_im;
    ov_d       = st_q[NSTEP].e_ov;
    dz_d       = 1'b0;
    f_re       = div_fin(st_q[NSTEP].neg_r, st_q[NSTEP].big_r, st_q[NSTEP].q_r);
    f_im       = div_fin(st_q[NSTEP].neg_i, st_q[NSTEP].big_i, st_q[NSTEP].q_i);
    zr         = ($signed(st_q[NSTEP].cz) + 34'sd8192) >>> 14;
    unique case (st_q[NSTEP].cmd)
      cnalu_pkg::CMD_DIV: begin
        if (st_q[NSTEP].dz) begin
          res_real_d = '0;
          res_imag_d = '0;
          ov_d       = 1'b0;
          dz_d       = 1'b1;
        end else begin
          res_real_d = f_re[31:0];
          res_imag_d = f_im[31:0];
          ov_d       = f_re[32] | f_im[32];
        end
      end
      cnalu_pkg::CMD_MAG: begin
        res_real_d = st_q[NSTEP].sroot[31] ? 32'h7FFF_FFFF : st_q[NSTEP].sroot;
        res_imag_d = '0;
        ov_d       = st_q[NSTEP].sroot[31];
      end
      cnalu_pkg::CMD_ARG: begin
        res_real_d = st_q[NSTEP].czero ? 32'd0 : zr[31:0];
        res_imag_d = '0;
        ov_d       = 1'b0;
      end
      default: begin
        res_real_d = st_q[NSTEP].e_re;
        res_imag_d = st_q[NSTEP].e_im;
        ov_d       = st_q[NSTEP].e_ov;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      it_v_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      p1_v_q  <= accept;
      p2_v_q  <= p1_v_q;
      it_v_q  <= {it_v_q[NSTEP-1:0], p2_v_q};
      out_v_q <= it_v_q[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    st_q[0]  <= it0_d;
    for (int k = 0; k < NSTEP; k++) begin
      st_q[k+1] <= st_d[k];
    end
    res_real_q <= res_real_d;
    res_imag_q <= res_imag_d;
    dz_q       <= dz_d;
    ov_q       <= ov_d;
  end

  assign res_valid_o      = out_v_q;
  assign res_real_o       = res_real_q;
  assign res_imag_o       = res_imag_q;
  assign divide_by_zero_o = dz_q;
  assign overflow_o       = ov_q;

endmodule
